### rtl/cpde_pkg.sv
// ----------------------------------------------------------------------------
// cpde_pkg
// Types and constants shared by the count profile delta encoder modules.
// ----------------------------------------------------------------------------
package cpde_pkg;

  localparam int COUNT_W  = 15;
  localparam int DIFF_W   = 16;
  localparam int RUN_W    = 6;
  localparam int REPORT_W = 48;
  localparam int MAX_BYTES = 3;

  localparam logic [RUN_W-1:0]   RUN_FULL    = 6'd63;
  localparam logic [COUNT_W-1:0] ABS_SHORT   = 15'd128;
  localparam logic [DIFF_W-1:0]  DIFF_POS_LIM = 16'd32;
  localparam logic [DIFF_W-1:0]  DIFF_NEG_LIM = 16'hffe1;
  localparam logic [1:0]         SHORT_TAG   = 2'b01;
  localparam logic               LONG_TAG    = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_BYTES-1:0] byte_list_t;

  // Per-read encoder context
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] prev;
    logic [RUN_W-1:0]   run;
  } enc_state_t;

  // Bytes produced by one sample
  typedef struct packed {
    byte_list_t bytes;
    logic [1:0] n;
  } enc_out_t;

endpackage

### rtl/cpde_encode.sv
// ----------------------------------------------------------------------------
// cpde_encode
// Combinational encoder for one count sample: absolute first count, delta
// bytes, zero-run handling and end-of-read run flush. Yields 0..3 bytes and
// the next per-read context.
// ----------------------------------------------------------------------------
module cpde_encode import cpde_pkg::*; (
  input  enc_state_t         cur,
  input  logic [COUNT_W-1:0] count,
  input  logic               read_last,
  output enc_state_t         nxt,
  output enc_out_t           res
);

  logic [DIFF_W-1:0] d;
  logic [RUN_W-1:0]  run_inc;

  assign d       = {1'b0, count} - {1'b0, cur.prev};
  assign run_inc = cur.run + RUN_W'(1);

  always_comb begin
    logic [RUN_W-1:0] run_n;
    logic [1:0]       k;
    res.bytes = '0;
    k         = 2'd0;
    run_n     = '0;

    if (cur.start) begin
      if (count < ABS_SHORT) begin
        res.bytes[k] = count[7:0];
        k = k + 2'd1;
      end else begin
        res.bytes[k] = {LONG_TAG, count[14:8]};
        k = k + 2'd1;
        res.bytes[k] = count[7:0];
        k = k + 2'd1;
      end
    end else if (d == '0) begin
      if (run_inc == RUN_FULL) begin
        res.bytes[k] = {2'b00, RUN_FULL};
        k = k + 2'd1;
      end else begin
        run_n = run_inc;
      end
    end else begin
      if (cur.run != '0) begin
        res.bytes[k] = {2'b00, cur.run};
        k = k + 2'd1;
      end
      if (d > DIFF_NEG_LIM || d < DIFF_POS_LIM) begin
        res.bytes[k] = {SHORT_TAG, d[5:0]};
        k = k + 2'd1;
      end else begin
        res.bytes[k] = {LONG_TAG, d[14:8]};
        k = k + 2'd1;
        res.bytes[k] = d[7:0];
        k = k + 2'd1;
      end
    end

    // end of read flushes whatever run is still pending
    if (read_last && run_n != '0) begin
      res.bytes[k] = {2'b00, run_n};
      k = k + 2'd1;
      run_n = '0;
    end

    res.n     = k;
    nxt.start = read_last;
    nxt.prev  = count;
    nxt.run   = run_n;
  end

endmodule

### rtl/count_profile_delta_encoder.sv
// ----------------------------------------------------------------------------
// count_profile_delta_encoder
// Delta / zero-run byte encoder for per-read k-mer count profiles.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat per count sample (kind = 0,
// count, read_last) or per empty read (kind = 1, other fields ignored).
// Output channel (out_valid / out_stall): one beat per encoded byte; an empty
// read gives one beat with has_byte = 0 and read_done = 1. The beat that
// closes a read carries read_done and the running byte offset. last_of_item
// marks the final beat caused by an input beat.
// A sample's first result shows on out_valid in the cycle after it is accepted.
// A zero delta that neither fills the run nor ends the read gives no beat.
// Throughput: one input beat per cycle while each sample yields at most one
// byte and out_stall is low; a multi-byte sample holds the input until the
// single result register, one byte per unstalled cycle, sends its last byte.
// Reset (rst, synchronous): the next sample starts a read, previous count,
// pending run and byte offset clear, the result register empties.
// A stalled receiver holds the current beat; the input stalls once the
// result register cannot drain its last byte in the same cycle.
// ----------------------------------------------------------------------------
module count_profile_delta_encoder import cpde_pkg::*; #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [COUNT_W-1:0]  count,
  input  logic                read_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                has_byte,
  output logic [7:0]          out_byte,
  output logic                read_done,
  output logic [REPORT_W-1:0] read_end_offset,
  output logic                last_of_item
);

  enc_state_t st, st_next;
  enc_out_t   enc;
  logic [OFFSET_BITS-1:0] offset, offset_next;

  // result register
  logic                   pend_valid;
  logic                   pend_empty;
  logic                   pend_last;
  byte_list_t             pend_bytes;
  logic [1:0]             pend_n;
  logic [1:0]             idx;
  logic [OFFSET_BITS-1:0] pend_off;

  logic accept, take, final_beat, load;
  logic [1:0] pend_cnt;

  cpde_encode u_enc (
    .cur       (st),
    .count     (count),
    .read_last (read_last),
    .nxt       (st_next),
    .res       (enc)
  );

  assign offset_next = offset + OFFSET_BITS'(enc.n);

  assign pend_cnt   = pend_empty ? 2'd1 : pend_n;
  assign final_beat = (idx == pend_cnt - 2'd1);
  assign take       = pend_valid && !out_stall;
  assign in_stall   = pend_valid && !(take && final_beat);
  assign accept     = in_valid && !in_stall;
  assign load       = accept && (kind || enc.n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.start   <= 1'b1;
      st.prev    <= '0;
      st.run     <= '0;
      offset     <= '0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (accept && !kind) begin
        st     <= st_next;
        offset <= offset_next;
      end
      if (load) begin
        pend_valid <= 1'b1;
        idx        <= '0;
      end else if (take) begin
        if (final_beat) pend_valid <= 1'b0;
        else            idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_empty <= kind;
      pend_last  <= read_last;
      pend_bytes <= enc.bytes;
      pend_n     <= enc.n;
      pend_off   <= kind ? offset : offset_next;
    end
  end

  logic [REPORT_W-1:0] off_rep;

  generate
    if (OFFSET_BITS >= REPORT_W) begin : g_cut
      assign off_rep = pend_off[REPORT_W-1:0];
    end else begin : g_ext
      assign off_rep = {{(REPORT_W-OFFSET_BITS){1'b0}}, pend_off};
    end
  endgenerate

  always_comb begin
    case (idx)
      2'd0:    out_byte = pend_bytes[0];
      2'd1:    out_byte = pend_bytes[1];
      default: out_byte = pend_bytes[2];
    endcase
    if (pend_empty) out_byte = '0;
  end

  assign out_valid       = pend_valid;
  assign has_byte        = !pend_empty;
  assign last_of_item    = final_beat;
  assign read_done       = pend_empty || (final_beat && pend_last);
  assign read_end_offset = read_done ? off_rep : '0;

endmodule

### rtl/cpde_checker.sv
// ----------------------------------------------------------------------------
// cpde_checker
// Port-level checks for count_profile_delta_encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cpde_checker import cpde_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                kind,
  input logic                out_valid,
  input logic                out_stall,
  input logic                has_byte,
  input logic [7:0]          out_byte,
  input logic                read_done,
  input logic [REPORT_W-1:0] read_end_offset,
  input logic                last_of_item
);

  // a stalled beat stays and holds its byte
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled output beat changed");

  // read close is always the final beat of its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_done |-> last_of_item)
    else $error("read_done on a non-final beat");

  // byteless beat only for an empty read
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> read_done && last_of_item && out_byte == 8'd0)
    else $error("malformed empty-read beat");

  // offset only reported with read_done
  a_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_done |-> read_end_offset == '0)
    else $error("offset reported outside read close");

  // an empty read accepted on a free output shows next cycle as a close
  a_empty_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind |=> out_valid && !has_byte)
    else $error("empty read not presented");

endmodule

bind count_profile_delta_encoder cpde_checker u_cpde_checker (.*);

### test/count_profile_delta_encoder_tb.sv
// ----------------------------------------------------------------------------
// count_profile_delta_encoder_tb
// Drives count samples and empty-read markers into the encoder with random
// input gaps and output backpressure. A local copy of the encoding rules
// predicts every output beat, and each received beat is checked in order.
// ----------------------------------------------------------------------------
module count_profile_delta_encoder_tb;
  import cpde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_GAP = 12;

  typedef struct packed {
    logic                has;
    logic [7:0]          data;
    logic                done;
    logic [REPORT_W-1:0] offset;
    logic                last;
  } profile_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                kind = 1'b0;
  logic [COUNT_W-1:0]  count = '0;
  logic                read_last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                has_byte;
  logic [7:0]          out_byte;
  logic                read_done;
  logic [REPORT_W-1:0] read_end_offset;
  logic                last_of_item;

  // encoder state as seen from outside
  logic                enc_start = 1'b1;
  logic [DIFF_W-1:0]   enc_prev = '0;
  logic [RUN_W-1:0]    enc_run = '0;
  logic [REPORT_W-1:0] enc_offset = '0;
  profile_beat_t       profile_q[$];

  int   errors = 0;
  int   cycle_count = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic rx_hold_on = 1'b0;
  int   rx_wait = 0;
  int   rx_draw;

  count_profile_delta_encoder DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .count           (count),
    .read_last       (read_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .has_byte        (has_byte),
    .out_byte        (out_byte),
    .read_done       (read_done),
    .read_end_offset (read_end_offset),
    .last_of_item    (last_of_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("count_profile_delta_encoder_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < 100)
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Encode one input beat and queue the output beats it should produce.
  function automatic void encode_count(input logic k, input logic [COUNT_W-1:0] c,
                                       input logic l);
    logic [7:0]        bytes[$];
    logic [DIFF_W-1:0] d;
    profile_beat_t     b;
    logic              fin;
    if (k) begin
      b.has = 1'b0;
      b.data = '0;
      b.done = 1'b1;
      b.offset = enc_offset;
      b.last = 1'b1;
      profile_q.push_back(b);
      return;
    end
    if (enc_start) begin
      if (c < ABS_SHORT) begin
        bytes.push_back(c[7:0]);
      end else begin
        bytes.push_back({LONG_TAG, c[14:8]});
        bytes.push_back(c[7:0]);
      end
      enc_run = '0;
    end else begin
      d = {1'b0, c} - enc_prev;
      if (d == '0) begin
        enc_run = enc_run + 1'b1;
        if (enc_run == RUN_FULL) begin
          bytes.push_back({2'b00, RUN_FULL});
          enc_run = '0;
        end
      end else begin
        if (enc_run != '0) begin
          bytes.push_back({2'b00, enc_run});
          enc_run = '0;
        end
        if (d > DIFF_NEG_LIM || d < DIFF_POS_LIM) begin
          bytes.push_back({SHORT_TAG, d[5:0]});
        end else begin
          bytes.push_back({LONG_TAG, d[14:8]});
          bytes.push_back(d[7:0]);
        end
      end
    end
    enc_prev = {1'b0, c};
    if (l) begin
      if (enc_run != '0) begin
        bytes.push_back({2'b00, enc_run});
        enc_run = '0;
      end
      enc_start = 1'b1;
    end else begin
      enc_start = 1'b0;
    end
    foreach (bytes[i]) begin
      fin = (i == bytes.size() - 1);
      enc_offset = enc_offset + 1'b1;
      b.has = 1'b1;
      b.data = bytes[i];
      b.done = fin && l;
      b.offset = (fin && l) ? enc_offset : '0;
      b.last = fin;
      profile_q.push_back(b);
    end
  endfunction

  // Receiver pacing: after each accepted beat, stall for a random count.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else if (rx_hold_on) begin
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else if (out_valid && !out_stall) begin
      rx_draw = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      rx_wait <= rx_draw;
      out_stall <= (rx_draw != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_beat
    profile_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (profile_q.size() == 0) begin
        report_mismatch("unexpected beat, byte", out_byte, 0);
      end else begin
        want = profile_q.pop_front();
        if (has_byte !== want.has) report_mismatch("has_byte", has_byte, want.has);
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (read_done !== want.done) report_mismatch("read_done", read_done, want.done);
        if (read_end_offset !== want.offset)
          report_mismatch("read_end_offset", read_end_offset, want.offset);
        if (last_of_item !== want.last)
          report_mismatch("last_of_item", last_of_item, want.last);
      end
    end
  end

  // Offer one beat; valid stays high between back-to-back beats.
  task automatic send_item(input logic k, input logic [COUNT_W-1:0] c, input logic l);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    count <= c;
    read_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_count(k, c, l);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Single-sample reads: short and long absolute forms at their boundaries.
  task automatic test_absolute_first;
    send_item(1'b0, 15'd0, 1'b1);
    send_item(1'b0, 15'd127, 1'b1);
    send_item(1'b0, 15'd128, 1'b1);
    send_item(1'b0, 15'd32767, 1'b1);
  endtask

  task automatic test_delta_classes;
    send_item(1'b0, 15'd1000, 1'b0);
    send_item(1'b0, 15'd1031, 1'b0);   // +31, short
    send_item(1'b0, 15'd1000, 1'b0);   // -31, long
    send_item(1'b0, 15'd970, 1'b0);    // -30, short
    send_item(1'b0, 15'd969, 1'b0);    // -1
    send_item(1'b0, 15'd1001, 1'b0);   // +32, long
    send_item(1'b0, 15'd0, 1'b0);
    send_item(1'b0, 15'd32767, 1'b0);
    send_item(1'b0, 15'd0, 1'b1);
  endtask

  task automatic test_zero_runs;
    send_item(1'b0, 15'd5, 1'b0);
    send_item(1'b0, 15'd5, 1'b0);
    send_item(1'b0, 15'd5, 1'b0);
    send_item(1'b0, 15'd300, 1'b0);    // run flush plus long delta: three beats
    send_item(1'b0, 15'd300, 1'b0);
    send_item(1'b0, 15'd300, 1'b1);    // pending run closes the read
  endtask

  // Empty reads at idle and in the middle of a read with a pending run.
  task automatic test_empty_reads;
    send_item(1'b1, 15'd0, 1'b0);
    send_item(1'b0, 15'd9, 1'b0);
    send_item(1'b0, 15'd9, 1'b0);
    send_item(1'b1, 15'd32767, 1'b1);
    send_item(1'b0, 15'd9, 1'b1);
  endtask

  // Receiver holds off while the sender keeps pushing random count samples.
  task automatic test_backpressure;
    int i;
    tx_idle_on = 1'b0;
    fork
      begin
        rx_hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_on <= 1'b0;
      end
      begin
        for (i = 0; i < 24; i++)
          send_item(1'b0, COUNT_W'($urandom), i == 23);
      end
    join
    tx_idle_on = 1'b1;
  endtask

  // Runs that sit just below, at and past the full-run byte.
  task automatic test_run_saturation;
    int lens[3];
    int i;
    int j;
    logic [COUNT_W-1:0] c;
    lens[0] = 62;
    lens[1] = 63;
    lens[2] = 127;
    for (i = 0; i < 3; i++) begin
      c = COUNT_W'($urandom);
      send_item(1'b0, c, 1'b0);
      for (j = 0; j < lens[i]; j++)
        send_item(1'b0, c, 1'b0);
      if ($urandom_range(0, 1) != 0)
        c = c ^ COUNT_W'($urandom_range(1, 3));
      send_item(1'b0, c, 1'b1);
    end
  endtask

  task automatic test_random_reads(input int n_items);
    int sent;
    int len;
    int i;
    int nxt;
    int mode;
    logic [COUNT_W-1:0] c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on <= ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 15) == 0) begin
        send_item(1'b1, COUNT_W'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
        c = ($urandom_range(0, 1) != 0) ? COUNT_W'($urandom_range(0, 127))
                                        : COUNT_W'($urandom);
        for (i = 0; i < len; i++) begin
          if (i != 0) begin
            if (len > 30)
              mode = ($urandom_range(0, 19) == 0) ? 2 : 0;
            else
              mode = $urandom_range(0, 6);
            nxt = int'(c);
            case (mode)
              0, 1: nxt = int'(c);
              2: nxt = int'(c) + int'($urandom_range(0, 62)) - 31;
              3: nxt = ($urandom_range(0, 1) != 0) ? int'(c) + int'($urandom_range(32, 2000))
                                                   : int'(c) - int'($urandom_range(32, 2000));
              4: nxt = int'($urandom_range(0, 32767));
              default: nxt = ($urandom_range(0, 1) != 0) ? 0 : 32767;
            endcase
            if (nxt < 0) nxt = 0;
            if (nxt > 32767) nxt = 32767;
            c = COUNT_W'(nxt);
            if ($urandom_range(0, 24) == 0) begin
              send_item(1'b1, COUNT_W'($urandom), 1'($urandom));
              sent++;
            end
          end
          send_item(1'b0, c, i == len - 1);
          sent++;
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_absolute_first;
    test_delta_classes;
    test_zero_runs;
    test_empty_reads;
    wait_drained;
    test_backpressure;
    wait_drained;
    test_run_saturation;
    test_random_reads(150);
    wait_drained;
    if (errors == 0)
      $display("count_profile_delta_encoder_tb: PASS");
    else
      $display("count_profile_delta_encoder_tb: FAIL");
    $finish;
  end

endmodule
